// ----- rtl/pcd_pkg.sv -----
`default_nettype none
package pcd_pkg;

   // field widths
   localparam int WORD_W  = 32;
   localparam int DT_W    = 16;
   localparam int ALPHA_W = 17;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 66;
   localparam int SUM_W   = 35;
   localparam int NUM_W   = 35;
   localparam int DVD_W   = NUM_W + DT_W;
   localparam int PADDR_W = 6;
   localparam int PDATA_W = 64;

   localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'd65536;

   // register indexes, paddr[5:3]
   localparam logic [2:0] REG_KP      = 3'd0;
   localparam logic [2:0] REG_KI      = 3'd1;
   localparam logic [2:0] REG_KD      = 3'd2;
   localparam logic [2:0] REG_OUT_LIM = 3'd3;
   localparam logic [2:0] REG_INT_LIM = 3'd4;
   localparam logic [2:0] REG_ALPHA   = 3'd5;
   localparam logic [2:0] REG_MODE    = 3'd6;

   // command codes
   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_M_FD,
      ST_M_RAW,
      ST_M_EDT,
      ST_M_P,
      ST_M_KIE,
      ST_M_KIEDT,
      ST_M_I,
      ST_M_D,
      ST_SEL,
      ST_M_I2,
      ST_FIN,
      ST_OUT
   } state_type;

   localparam logic signed [PROD_W-1:0] MAX66 = 66'sd2147483647;
   localparam logic signed [PROD_W-1:0] MIN66 = -66'sd2147483648;

   // saturate a wide value to signed 32 bits
   function automatic logic signed [WORD_W-1:0] sat32_f(input logic signed [PROD_W-1:0] x);
      logic signed [WORD_W-1:0] r;
      begin
         if (x > MAX66) begin
            r = 32'sh7FFFFFFF;
         end else if (x < MIN66) begin
            r = 32'sh80000000;
         end else begin
            r = x[WORD_W-1:0];
         end
         return r;
      end
   endfunction

   // q16 product: floor shift by 16, then saturate
   function automatic logic signed [WORD_W-1:0] q16_f(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] s;
      begin
         s = p >>> 16;
         return sat32_f(s);
      end
   endfunction

   // clamp with the minimum tested first
   function automatic logic signed [SUM_W-1:0] clamp_f(input logic signed [SUM_W-1:0] v,
                                                       input logic signed [WORD_W-1:0] lo,
                                                       input logic signed [WORD_W-1:0] hi);
      logic signed [SUM_W-1:0] lo_x;
      logic signed [SUM_W-1:0] hi_x;
      logic signed [SUM_W-1:0] r;
      begin
         lo_x = {{(SUM_W-WORD_W){lo[WORD_W-1]}}, lo};
         hi_x = {{(SUM_W-WORD_W){hi[WORD_W-1]}}, hi};
         if (v < lo_x) begin
            r = lo_x;
         end else if (v > hi_x) begin
            r = hi_x;
         end else begin
            r = v;
         end
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ----- rtl/pcd_req_if.sv -----
`default_nettype none
interface pcd_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] reference;
   logic [31:0] measurement;
   logic [15:0] time_step;

   modport source (output valid, command, reference, measurement, time_step, input ready);
   modport sink (input valid, command, reference, measurement, time_step, output ready);
endinterface
`default_nettype wire

// ----- rtl/pcd_rsp_if.sv -----
`default_nettype none
interface pcd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] drive;
   logic        saturated;

   modport source (output valid, drive, saturated, input ready);
   modport sink (input valid, drive, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/pcd_mul.sv -----
`default_nettype none
module pcd_mul
   import pcd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [MUL_W-1:0]  a,
   input  wire logic signed [MUL_W-1:0]  b,
   output logic                          done,
   output logic signed [PROD_W-1:0]      prod
);

   logic [MUL_W-1:0]  mcand_ff;
   logic [MUL_W-1:0]  hi_ff;
   logic [MUL_W-1:0]  lo_ff;
   logic [5:0]        cnt_ff;
   logic              busy_ff;
   logic              neg_ff;
   logic              done_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [MUL_W:0]    sum_in;
   logic [MUL_W-1:0]  abs_a;
   logic [MUL_W-1:0]  abs_b;

   // magnitudes and one shift-add step
   always_comb begin
      abs_a  = a[MUL_W-1] ? (~a + 1'b1) : a;
      abs_b  = b[MUL_W-1] ? (~b + 1'b1) : b;
      sum_in = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
   end

   // one multiplier bit per cycle, sign fixed at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mcand_ff <= abs_a;
            lo_ff    <= abs_b;
            hi_ff    <= '0;
            neg_ff   <= a[MUL_W-1] ^ b[MUL_W-1];
            cnt_ff   <= 6'(MUL_W);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               hi_ff  <= sum_in[MUL_W:1];
               lo_ff  <= {sum_in[0], lo_ff[MUL_W-1:1]};
               cnt_ff <= cnt_ff - 1'b1;
            end else begin
               prod_ff <= neg_ff ? -$signed({hi_ff, lo_ff}) : $signed({hi_ff, lo_ff});
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule
`default_nettype wire

// ----- rtl/pcd_div.sv -----
`default_nettype none
module pcd_div
   import pcd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [NUM_W-1:0]  num,
   input  wire logic [DT_W-1:0]          dt,
   output logic                          done,
   output logic signed [WORD_W-1:0]      quot
);

   logic [DVD_W-1:0]  dvd_ff;
   logic [DVD_W-1:0]  quo_ff;
   logic [DT_W-1:0]   rem_ff;
   logic [5:0]        cnt_ff;
   logic              busy_ff;
   logic              neg_ff;
   logic              done_ff;
   logic signed [WORD_W-1:0] quot_ff;
   logic [NUM_W-1:0]  abs_num;
   logic [DT_W:0]     trial;
   logic              fits;
   logic              sat_pos;
   logic              sat_neg;

   // one restoring step
   always_comb begin
      abs_num = num[NUM_W-1] ? (~num + 1'b1) : num;
      trial   = {rem_ff, dvd_ff[DVD_W-1]};
      fits    = (trial >= {1'b0, dt});
      sat_pos = |quo_ff[DVD_W-1:WORD_W-1];
      sat_neg = (|quo_ff[DVD_W-1:WORD_W]) || (quo_ff[WORD_W-1] && (|quo_ff[WORD_W-2:0]));
   end

   // one quotient bit per cycle, truncation toward zero
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff  <= {abs_num, {DT_W{1'b0}}};
            quo_ff  <= '0;
            rem_ff  <= '0;
            neg_ff  <= num[NUM_W-1];
            cnt_ff  <= 6'(DVD_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               rem_ff <= fits ? DT_W'(trial - {1'b0, dt}) : trial[DT_W-1:0];
               quo_ff <= {quo_ff[DVD_W-2:0], fits};
               dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
               cnt_ff <= cnt_ff - 1'b1;
            end else begin
               if (neg_ff) begin
                  quot_ff <= sat_neg ? 32'sh80000000 : -$signed(quo_ff[WORD_W-1:0]);
               end else begin
                  quot_ff <= sat_pos ? 32'sh7FFFFFFF : $signed(quo_ff[WORD_W-1:0]);
               end
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

// ----- rtl/pid_controller_dual_mode_top.sv -----
// channel   | direction | payload                                   | transfer
// req_ch    | in        | command, reference, measurement, time_step | valid & ready
// rsp_ch    | out       | drive, saturated                           | valid & ready
// csr (apb) | in        | 64-bit registers at 8*index                | psel & penable & pwrite
//
// an update item runs one serial divide and seven serial multiplies, the
// multiplies on one shared shift-add unit, all back to back. clear and zero
// time step items skip the arithmetic. one item in flight at a time;
// the next is taken while the last result waits in the output register.
// reset (synchronous) clears registers and controller state.
`default_nettype none
module pid_controller_dual_mode_top
   import pcd_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   pcd_req_if.sink                  req_ch,
   pcd_rsp_if.source                rsp_ch,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [PADDR_W-1:0]  paddr,
   input  wire logic [PDATA_W-1:0]  pwdata,
   output logic [PDATA_W-1:0]       prdata,
   output logic                     pready
);

   // configuration
   logic [WORD_W-1:0]  kp_ff, ki_ff, kd_ff;
   logic [63:0]        out_lim_ff, int_lim_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [1:0]         mode_ff;

   // controller state
   logic signed [WORD_W-1:0] iacc_ff, le_ff, oe_ff, lm_ff, ld_ff, fd_ff;

   // work registers
   logic signed [WORD_W-1:0] err_ff, meas_ff, raw_ff, deriv_ff, cand_ff, sel_ff;
   logic signed [WORD_W-1:0] pterm_ff, kie_ff, iterm_ff, dterm_ff;
   logic [DT_W-1:0]          dt_ff;
   logic signed [PROD_W-1:0] pfd_ff;
   logic signed [WORD_W-1:0] res_drive_ff;
   logic                     res_sat_ff;
   logic                     issued_ff, issued_in;
   state_type                state_ff, state_in;

   // output register
   logic                     rsp_valid_ff;
   logic [WORD_W-1:0]        rsp_drive_ff;
   logic                     rsp_sat_ff;

   // shared units
   logic                     mul_start, mul_done, div_start, div_done;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_prod;
   logic signed [NUM_W-1:0]  div_num;
   logic signed [WORD_W-1:0] div_quot;

   // combinational helpers
   logic                     incr, aw, csr_wr, req_take, out_load;
   logic [ALPHA_W-1:0]       alpha_eff, alpha_rest;
   logic signed [WORD_W-1:0] out_min, out_max, int_min, int_max;
   logic signed [WORD_W-1:0] q16_prod, err_in, sel_in;
   logic signed [PROD_W-1:0] ref_minus;
   logic signed [PROD_W-1:0] deriv_sum;
   logic signed [PROD_W-1:0] cand_sum;
   logic signed [SUM_W-1:0]  unsat_c, drive_c, cand_cl;
   logic signed [SUM_W-1:0]  out_min_x, out_max_x;
   logic signed [MUL_W-1:0]  err_diff;

   assign incr      = mode_ff[0];
   assign aw        = mode_ff[1];
   assign alpha_eff = (alpha_ff > ONE_Q16) ? ONE_Q16 : alpha_ff;
   assign alpha_rest = ONE_Q16 - alpha_eff;
   assign out_min   = out_lim_ff[31:0];
   assign out_max   = out_lim_ff[63:32];
   assign int_min   = int_lim_ff[31:0];
   assign int_max   = int_lim_ff[63:32];
   assign csr_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign req_take  = req_ch.valid && req_ch.ready;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   // configuration write
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0; ki_ff <= '0; kd_ff <= '0;
         out_lim_ff <= '0; int_lim_ff <= '0; alpha_ff <= '0; mode_ff <= '0;
      end else if (csr_wr) begin
         case (paddr[5:3])
            REG_KP:      kp_ff      <= pwdata[31:0];
            REG_KI:      ki_ff      <= pwdata[31:0];
            REG_KD:      kd_ff      <= pwdata[31:0];
            REG_OUT_LIM: out_lim_ff <= pwdata;
            REG_INT_LIM: int_lim_ff <= pwdata;
            REG_ALPHA:   alpha_ff   <= pwdata[ALPHA_W-1:0];
            REG_MODE:    mode_ff    <= pwdata[1:0];
            default:     ;
         endcase
      end
   end

   // configuration read
   always_comb begin
      case (paddr[5:3])
         REG_KP:      prdata = {32'd0, kp_ff};
         REG_KI:      prdata = {32'd0, ki_ff};
         REG_KD:      prdata = {32'd0, kd_ff};
         REG_OUT_LIM: prdata = out_lim_ff;
         REG_INT_LIM: prdata = int_lim_ff;
         REG_ALPHA:   prdata = {47'd0, alpha_ff};
         REG_MODE:    prdata = {62'd0, mode_ff};
         default:     prdata = '0;
      endcase
   end

   // error, sums and clamps
   always_comb begin
      out_min_x = {{3{out_min[31]}}, out_min};
      out_max_x = {{3{out_max[31]}}, out_max};
      ref_minus = {{34{req_ch.reference[31]}}, req_ch.reference}
                - {{34{req_ch.measurement[31]}}, req_ch.measurement};
      err_in    = sat32_f(ref_minus);
      err_diff  = {err_ff[31], err_ff} - {le_ff[31], le_ff};
      q16_prod  = q16_f(mul_prod);
      deriv_sum = (pfd_ff + mul_prod) >>> 16;
      cand_sum  = {{34{iacc_ff[31]}}, iacc_ff} + {{34{q16_prod[31]}}, q16_prod};
      if (incr) begin
         div_num = {{3{err_ff[31]}}, err_ff} - {{2{le_ff[31]}}, le_ff, 1'b0}
                 + {{3{oe_ff[31]}}, oe_ff};
         unsat_c = {{3{ld_ff[31]}}, ld_ff} + {{3{pterm_ff[31]}}, pterm_ff}
                 + {{3{iterm_ff[31]}}, iterm_ff} + {{3{dterm_ff[31]}}, dterm_ff};
      end else begin
         div_num = {{3{lm_ff[31]}}, lm_ff} - {{3{meas_ff[31]}}, meas_ff};
         unsat_c = {{3{pterm_ff[31]}}, pterm_ff}
                 + {{3{iterm_ff[31]}}, iterm_ff} + {{3{dterm_ff[31]}}, dterm_ff};
      end
      drive_c = clamp_f(unsat_c, out_min, out_max);
      cand_cl = clamp_f({{3{cand_ff[31]}}, cand_ff}, int_min, int_max);
      // with anti-windup on and the output clamped, keep the old integral unless the error pulls back inside the limits
      if (aw && (unsat_c != drive_c)
          && !((unsat_c > out_max_x && err_ff[31])
               || (unsat_c < out_min_x && !err_ff[31] && err_ff != '0))) begin
         sel_in = iacc_ff;
      end else begin
         sel_in = cand_cl[WORD_W-1:0];
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_M_FD:    begin mul_a = {16'd0, alpha_eff};  mul_b = {fd_ff[31], fd_ff}; end
         ST_M_RAW:   begin mul_a = {16'd0, alpha_rest}; mul_b = {raw_ff[31], raw_ff}; end
         ST_M_EDT:   begin mul_a = {err_ff[31], err_ff}; mul_b = {17'd0, dt_ff}; end
         ST_M_P:     begin
            mul_a = {kp_ff[31], kp_ff};
            mul_b = incr ? err_diff : {err_ff[31], err_ff};
         end
         ST_M_KIE:   begin mul_a = {ki_ff[31], ki_ff}; mul_b = {err_ff[31], err_ff}; end
         ST_M_KIEDT: begin mul_a = {kie_ff[31], kie_ff}; mul_b = {17'd0, dt_ff}; end
         ST_M_I:     begin mul_a = {ki_ff[31], ki_ff}; mul_b = {cand_ff[31], cand_ff}; end
         ST_M_D:     begin mul_a = {kd_ff[31], kd_ff}; mul_b = {deriv_ff[31], deriv_ff}; end
         ST_M_I2:    begin mul_a = {ki_ff[31], ki_ff}; mul_b = {sel_ff[31], sel_ff}; end
         default:    ;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      mul_start = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_ch.command == CMD_CLEAR || req_ch.time_step == '0) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            div_start = !issued_ff;
            issued_in = 1'b1;
            if (div_done) begin
               issued_in = 1'b0;
               state_in  = ST_M_FD;
            end
         end
         ST_M_FD, ST_M_RAW, ST_M_EDT, ST_M_P, ST_M_KIE, ST_M_KIEDT,
         ST_M_I, ST_M_D, ST_M_I2: begin
            mul_start = !issued_ff;
            issued_in = 1'b1;
            if (mul_done) begin
               issued_in = 1'b0;
               case (state_ff)
                  ST_M_FD:    state_in = ST_M_RAW;
                  ST_M_RAW:   state_in = ST_M_EDT;
                  ST_M_EDT:   state_in = ST_M_P;
                  ST_M_P:     state_in = incr ? ST_M_KIE : ST_M_I;
                  ST_M_KIE:   state_in = ST_M_KIEDT;
                  ST_M_KIEDT: state_in = ST_M_D;
                  ST_M_I:     state_in = ST_M_D;
                  ST_M_D:     state_in = ST_SEL;
                  default:    state_in = ST_FIN;
               endcase
            end
         end
         ST_SEL:  state_in = incr ? ST_FIN : ST_M_I2;
         ST_FIN:  state_in = ST_OUT;
         ST_OUT:  if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

   // datapath and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         iacc_ff <= '0; le_ff <= '0; oe_ff <= '0;
         lm_ff <= '0; ld_ff <= '0; fd_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  err_ff  <= err_in;
                  meas_ff <= req_ch.measurement;
                  dt_ff   <= req_ch.time_step;
                  if (req_ch.command == CMD_CLEAR) begin
                     iacc_ff <= '0; le_ff <= '0; oe_ff <= '0;
                     lm_ff <= '0; ld_ff <= '0; fd_ff <= '0;
                     res_drive_ff <= '0;
                  end else begin
                     res_drive_ff <= ld_ff;
                  end
                  res_sat_ff <= 1'b0;
               end
            end
            ST_DIV:     if (div_done) raw_ff <= div_quot;
            ST_M_FD:    if (mul_done) pfd_ff <= mul_prod;
            ST_M_RAW: begin
               if (mul_done) begin
                  deriv_ff <= sat32_f(deriv_sum);
                  fd_ff    <= sat32_f(deriv_sum);
               end
            end
            ST_M_EDT:   if (mul_done) cand_ff <= sat32_f(cand_sum);
            ST_M_P:     if (mul_done) pterm_ff <= q16_prod;
            ST_M_KIE:   if (mul_done) kie_ff <= q16_prod;
            ST_M_KIEDT: if (mul_done) iterm_ff <= q16_prod;
            ST_M_I:     if (mul_done) iterm_ff <= q16_prod;
            ST_M_D:     if (mul_done) dterm_ff <= q16_prod;
            ST_M_I2:    if (mul_done) iterm_ff <= q16_prod;
            ST_SEL: begin
               sel_ff  <= sel_in;
               iacc_ff <= sel_in;
            end
            ST_FIN: begin
               res_drive_ff <= drive_c[WORD_W-1:0];
               res_sat_ff   <= (unsat_c != drive_c);
               ld_ff        <= drive_c[WORD_W-1:0];
               oe_ff        <= le_ff;
               le_ff        <= err_ff;
               lm_ff        <= meas_ff;
            end
            default: ;
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
         rsp_drive_ff <= res_drive_ff;
         rsp_sat_ff   <= res_sat_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign req_ch.ready     = (state_ff == ST_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.drive     = rsp_drive_ff;
   assign rsp_ch.saturated = rsp_sat_ff;

   pcd_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   pcd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .dt    (dt_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

endmodule
`default_nettype wire
